// ----- src/mcmq_pkg.sv -----
// Shared constants, codes and types of the multi-channel message queue.
// Used by mcmq_route and multi_channel_message_queue; depends on nothing.
package mcmq_pkg;

   localparam int CHANNELS  = 8;
   localparam int SLOTS     = 8;
   localparam int MAX_BEATS = 8;
   localparam int CAP_BYTES = MAX_BEATS * 8;

   localparam int CH_W   = $clog2(CHANNELS);
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int BEAT_W = $clog2(MAX_BEATS);
   localparam int SIZE_W = 7;
   localparam int CNT_W  = 4;

   typedef enum logic [1:0] {
      OP_SEND  = 2'd0,
      OP_RECV  = 2'd1,
      OP_TABLE = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_NOACT  = 2'd1;
   localparam logic [1:0] ST_NOTFND = 2'd2;

   typedef struct packed {
      logic            hit;
      logic [CH_W-1:0] idx;
   } route_match_type;

endpackage

// ----- src/mcmq_route.sv -----
// Channel route table and its source and destination lookups.
// Depends on mcmq_pkg.
module mcmq_route (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [mcmq_pkg::CH_W-1:0]      wr_idx,
   input  logic [31:0]                    wr_data,
   input  logic [mcmq_pkg::CNT_W-1:0]     channel_count,
   input  logic [7:0]                     part_id,
   input  logic [7:0]                     port_id,
   output mcmq_pkg::route_match_type      src_match,
   output mcmq_pkg::route_match_type      dst_match
);

   logic [31:0] table_ff [mcmq_pkg::CHANNELS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_idx] <= wr_data;
      end
   end

   always_comb begin
      src_match = '0;
      dst_match = '0;
      for (int i = mcmq_pkg::CHANNELS - 1; i >= 0; i--) begin
         if (i < int'(channel_count)) begin
            if (table_ff[i][31:24] == part_id && table_ff[i][23:16] == port_id) begin
               src_match.hit = 1'b1;
               src_match.idx = mcmq_pkg::CH_W'(i);
            end
            if (table_ff[i][15:8] == part_id && table_ff[i][7:0] == port_id) begin
               dst_match.hit = 1'b1;
               dst_match.idx = mcmq_pkg::CH_W'(i);
            end
         end
      end
   end

endmodule

// ----- src/multi_channel_message_queue.sv -----
// Top level of the multi-channel message queue: send assembly, receive streaming.
// Depends on mcmq_pkg and mcmq_route.
// A send beat is accepted while idle, and a beat that is not the last leaves the block
// idle; the last beat enters S_FINISH, which holds busy while the final partial word,
// the slot size and the tail pointer are written, and its status appears the cycle
// after. A receive streams one beat per cycle from the message memory and keeps busy
// high until its final beat. Table writes and failed receives answer the cycle after
// the request. Results cannot be stalled.
module multi_channel_message_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_part_id,
   input  logic [7:0]  req_port_id,
   input  logic [2:0]  req_entry_index,
   input  logic [7:0]  req_peer_part_id,
   input  logic [7:0]  req_peer_port_id,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_byte_count,
   input  logic        req_last_beat,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_read_word,
   output logic [3:0]  rsp_read_bytes,
   output logic [6:0]  rsp_message_size,
   output logic        rsp_final_res,
   input  logic        csr_write_enable,
   input  logic [3:0]  csr_write_data
);

   localparam int CH_W   = mcmq_pkg::CH_W;
   localparam int SLOT_W = mcmq_pkg::SLOT_W;
   localparam int BEAT_W = mcmq_pkg::BEAT_W;
   localparam int SIZE_W = mcmq_pkg::SIZE_W;
   localparam int SA_W   = CH_W + SLOT_W;
   localparam int WA_W   = SA_W + BEAT_W;

   typedef enum logic [1:0] {S_IDLE, S_FINISH, S_RECV} state_type;
   typedef enum logic [1:0] {M_IDLE, M_STORE, M_FULL, M_MISS} mode_type;

   state_type                    st_ff, st_in;
   mode_type                     mode_ff, mode_in;
   logic [CH_W-1:0]              sch_ff, sch_in;
   logic [SIZE_W-1:0]            off_ff, off_in;
   logic [63:0]                  buf_ff, buf_in;
   logic [1:0]                   fstat_ff, fstat_in;
   logic [CH_W-1:0]              rch_ff, rch_in;
   logic [BEAT_W-1:0]            rk_ff, rk_in;
   logic                         first_ff, first_in;
   logic [SIZE_W-1:0]            rsize_ff, rsize_in;
   logic [mcmq_pkg::CNT_W-1:0]   ccount_ff;
   logic [SLOT_W-1:0]            head_ff [mcmq_pkg::CHANNELS];
   logic [SLOT_W-1:0]            tail_ff [mcmq_pkg::CHANNELS];

   logic                         rv_in;
   logic [1:0]                   rst_in;
   logic [63:0]                  rw_in;
   logic [3:0]                   rb_in;
   logic [SIZE_W-1:0]            rs_in;
   logic                         rf_in;
   logic                         rsp_valid_ff, rsp_final_ff;
   logic [1:0]                   rsp_status_ff;
   logic [63:0]                  rsp_word_ff;
   logic [3:0]                   rsp_bytes_ff;
   logic [SIZE_W-1:0]            rsp_size_ff;

   logic [SIZE_W-1:0]            size_mem [mcmq_pkg::CHANNELS * mcmq_pkg::SLOTS];
   logic [63:0]                  msg_mem
                                 [mcmq_pkg::CHANNELS * mcmq_pkg::SLOTS * mcmq_pkg::MAX_BEATS];
   logic [SIZE_W-1:0]            size_q;
   logic [63:0]                  word_q;
   logic                         msg_we, size_we;
   logic [WA_W-1:0]              msg_waddr, msg_raddr;
   logic [SA_W-1:0]              size_waddr, size_raddr;
   logic [63:0]                  msg_wdata;

   mcmq_pkg::route_match_type    src_m, dst_m;
   logic                         accept, tbl_we;
   logic                         head_adv, tail_adv;
   logic [CH_W-1:0]              head_ch;

   // send datapath
   mode_type                     mode_e;
   logic [CH_W-1:0]              sch_e;
   logic [SIZE_W-1:0]            off_e, room, alw, noff;
   logic [3:0]                   nb_in;
   logic [63:0]                  buf_e, data_m;
   logic [127:0]                 merged;
   logic                         complete;

   // receive datapath
   logic [SIZE_W-1:0]            rsz;
   logic [SIZE_W:0]              base, left;
   logic [3:0]                   nb_out;
   logic                         rfin;
   logic [63:0]                  rmask;

   assign accept = start && (st_ff == S_IDLE);
   assign busy   = (st_ff != S_IDLE);
   assign tbl_we = accept && req_opcode == mcmq_pkg::OP_TABLE && mode_ff == M_IDLE
                   && int'(req_entry_index) < mcmq_pkg::CHANNELS;

   mcmq_route u_route (
      .clock        (clock),
      .wr_en        (tbl_we),
      .wr_idx       (CH_W'(req_entry_index)),
      .wr_data      ({req_part_id, req_port_id, req_peer_part_id, req_peer_port_id}),
      .channel_count(ccount_ff),
      .part_id      (req_part_id),
      .port_id      (req_port_id),
      .src_match    (src_m),
      .dst_match    (dst_m)
   );

   always_comb begin
      if (mode_ff == M_IDLE) begin
         if (!src_m.hit) begin
            mode_e = M_MISS;
         end else if (head_ff[src_m.idx] == tail_ff[src_m.idx] + 1'b1) begin
            mode_e = M_FULL;
         end else begin
            mode_e = M_STORE;
         end
         sch_e = src_m.idx;
         off_e = '0;
         buf_e = '0;
      end else begin
         mode_e = mode_ff;
         sch_e  = sch_ff;
         off_e  = off_ff;
         buf_e  = buf_ff;
      end
      nb_in = (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
      room  = SIZE_W'(mcmq_pkg::CAP_BYTES) - off_e;
      alw   = (SIZE_W'(nb_in) > room) ? room : SIZE_W'(nb_in);
      for (int b = 0; b < 8; b++) begin
         data_m[8*b +: 8] = (b < int'(alw)) ? req_data_word[8*b +: 8] : 8'h00;
      end
      merged   = {64'b0, buf_e} | ({64'b0, data_m} << {off_e[2:0], 3'b000});
      complete = ({1'b0, off_e[2:0]} + alw) >= SIZE_W'(8);
      noff     = off_e + alw;
   end

   always_comb begin
      rsz   = first_ff ? ((size_q > SIZE_W'(mcmq_pkg::CAP_BYTES))
                          ? SIZE_W'(mcmq_pkg::CAP_BYTES) : size_q) : rsize_ff;
      base  = {2'b00, rk_ff, 3'b000};
      left  = {1'b0, rsz} - base;
      nb_out = (left > (SIZE_W+1)'(8)) ? 4'd8 : left[3:0];
      rfin  = {1'b0, rsz} <= base + (SIZE_W+1)'(8);
      for (int b = 0; b < 8; b++) begin
         rmask[8*b +: 8] = (b < int'(nb_out)) ? 8'hFF : 8'h00;
      end
   end

   always_comb begin
      st_in    = st_ff;
      mode_in  = mode_ff;
      sch_in   = sch_ff;
      off_in   = off_ff;
      buf_in   = buf_ff;
      fstat_in = fstat_ff;
      rch_in   = rch_ff;
      rk_in    = rk_ff;
      first_in = 1'b0;
      rsize_in = rsize_ff;
      rv_in    = 1'b0;
      rst_in   = mcmq_pkg::ST_OK;
      rw_in    = '0;
      rb_in    = '0;
      rs_in    = '0;
      rf_in    = 1'b1;
      msg_we   = 1'b0;
      msg_waddr = {sch_e, tail_ff[sch_e], off_e[BEAT_W+2:3]};
      msg_wdata = merged[63:0];
      size_we  = 1'b0;
      size_waddr = {sch_ff, tail_ff[sch_ff]};
      msg_raddr  = {dst_m.idx, head_ff[dst_m.idx], BEAT_W'(0)};
      size_raddr = {dst_m.idx, head_ff[dst_m.idx]};
      head_adv = 1'b0;
      tail_adv = 1'b0;
      head_ch  = rch_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  mcmq_pkg::OP_SEND: begin
                     mode_in = mode_e;
                     sch_in  = sch_e;
                     off_in  = noff;
                     if (mode_e == M_STORE) begin
                        msg_we = complete;
                        buf_in = complete ? merged[127:64] : merged[63:0];
                     end
                     if (req_last_beat) begin
                        st_in = S_FINISH;
                        fstat_in = (mode_e == M_STORE) ? mcmq_pkg::ST_OK :
                                   (mode_e == M_FULL) ? mcmq_pkg::ST_NOACT :
                                   mcmq_pkg::ST_NOTFND;
                     end
                  end
                  mcmq_pkg::OP_RECV: begin
                     if (!dst_m.hit) begin
                        rv_in  = 1'b1;
                        rst_in = mcmq_pkg::ST_NOTFND;
                     end else if (head_ff[dst_m.idx] == tail_ff[dst_m.idx]) begin
                        rv_in  = 1'b1;
                        rst_in = mcmq_pkg::ST_NOACT;
                     end else begin
                        st_in    = S_RECV;
                        rch_in   = dst_m.idx;
                        rk_in    = '0;
                        first_in = 1'b1;
                     end
                  end
                  mcmq_pkg::OP_TABLE: begin
                     rv_in  = 1'b1;
                     rst_in = tbl_we ? mcmq_pkg::ST_OK : mcmq_pkg::ST_NOACT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FINISH: begin
            if (mode_ff == M_STORE) begin
               msg_waddr = {sch_ff, tail_ff[sch_ff], off_ff[BEAT_W+2:3]};
               msg_wdata = buf_ff;
               msg_we    = (off_ff[2:0] != 3'd0);
               size_we   = 1'b1;
               tail_adv  = 1'b1;
            end
            rv_in   = 1'b1;
            rst_in  = fstat_ff;
            mode_in = M_IDLE;
            off_in  = '0;
            st_in   = S_IDLE;
         end
         S_RECV: begin
            msg_raddr = {rch_ff, head_ff[rch_ff], rk_ff + 1'b1};
            rsize_in  = rsz;
            rv_in  = 1'b1;
            rw_in  = word_q & rmask;
            rb_in  = nb_out;
            rs_in  = rsz;
            rf_in  = rfin;
            rk_in  = rk_ff + 1'b1;
            if (rfin) begin
               head_adv = 1'b1;
               st_in    = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (msg_we) begin
         msg_mem[msg_waddr] <= msg_wdata;
      end
      if (size_we) begin
         size_mem[size_waddr] <= off_ff;
      end
      word_q <= msg_mem[msg_raddr];
      size_q <= size_mem[size_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         mode_ff      <= M_IDLE;
         sch_ff       <= '0;
         off_ff       <= '0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ccount_ff    <= '0;
         for (int i = 0; i < mcmq_pkg::CHANNELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         st_ff        <= st_in;
         mode_ff      <= mode_in;
         sch_ff       <= sch_in;
         off_ff       <= off_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rv_in;
         if (csr_write_enable) begin
            ccount_ff <= csr_write_data;
         end
         if (head_adv) begin
            head_ff[head_ch] <= head_ff[head_ch] + 1'b1;
         end
         if (tail_adv) begin
            tail_ff[sch_ff] <= tail_ff[sch_ff] + 1'b1;
         end
      end
      buf_ff        <= buf_in;
      fstat_ff      <= fstat_in;
      rch_ff        <= rch_in;
      rk_ff         <= rk_in;
      rsize_ff      <= rsize_in;
      rsp_status_ff <= rst_in;
      rsp_word_ff   <= rw_in;
      rsp_bytes_ff  <= rb_in;
      rsp_size_ff   <= rs_in;
      rsp_final_ff  <= rf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_read_word    = rsp_word_ff;
   assign rsp_read_bytes   = rsp_bytes_ff;
   assign rsp_message_size = rsp_size_ff;
   assign rsp_final_res    = rsp_final_ff;

`ifndef NO_ASSERTIONS
   a_finish_clears_mode: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_FINISH |=> mode_ff == M_IDLE && st_ff == S_IDLE)
      else $error("send mode not cleared after commit");
   a_recv_no_write: assert property (@(posedge clock) disable iff (reset)
      st_ff == S_RECV |-> !msg_we && !size_we)
      else $error("message memory written during receive stream");
   a_recv_final_idle: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_RECV && rfin) |=> st_ff == S_IDLE && rsp_valid && rsp_final_res)
      else $error("receive stream did not end on final beat");
   a_send_offset_cap: assert property (@(posedge clock) disable iff (reset)
      off_ff <= SIZE_W'(mcmq_pkg::CAP_BYTES))
      else $error("send offset beyond slot capacity");
`endif

endmodule
